// File: src/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg: shared definitions of the pursuit camera follower
// Widths, register indexes and the request/response bundle of the serial unit.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 8;

  // speed limit and gain registers are 16 bit
  localparam int REG_W  = 16;
  localparam int VMAG_W = REG_W + 1;           // velocity magnitude before limiting
  localparam int VEL_W  = VMAG_W + 1;          // signed velocity
  localparam int DIFF_W = COORD_BITS + 1;      // signed target distance per axis

  localparam int OPW   = (DIFF_W > VMAG_W) ? DIFF_W : VMAG_W;
  localparam int PRODW = 2 * OPW;
  localparam int CNTW  = $clog2(PRODW + 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_HEIGHT = 3'd5;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } op_e;

  typedef struct packed {
    logic             start;
    op_e              op;
    logic [PRODW-1:0] a;
    logic [OPW-1:0]   b;
  } ser_req_t;

  typedef struct packed {
    logic             done;
    logic [PRODW-1:0] res;
  } ser_rsp_t;

endpackage

// File: src/pcf_serial.sv
// ----------------------------------------------------------------------------
// pcf_serial: bit-serial multiply, divide and square root
// Shift-add multiply, restoring divide (one quotient bit per cycle) and
// digit-by-digit square root (one root bit per cycle).
// ----------------------------------------------------------------------------
module pcf_serial (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcf_pkg::ser_req_t req_i,
  output pcf_pkg::ser_rsp_t rsp_o
);

  localparam int OPW   = pcf_pkg::OPW;
  localparam int PRODW = pcf_pkg::PRODW;
  localparam int CNTW  = pcf_pkg::CNTW;
  localparam int RW    = OPW + 3;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  pcf_pkg::op_e        op_q, op_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic [PRODW-1:0]    acc_q, acc_d;
  logic [PRODW-1:0]    opa_q, opa_d;
  logic [OPW-1:0]      opb_q, opb_d;
  logic [RW-1:0]       rem_q, rem_d;

  logic [CNTW-1:0]     last_cnt;
  logic [PRODW-1:0]    mul_sum;
  logic [RW-1:0]       div_rem;
  logic                div_ge;
  logic [RW-1:0]       sq_rem;
  logic [RW-1:0]       sq_trial;
  logic                sq_ge;

  assign mul_sum  = acc_q + (opb_q[0] ? opa_q : '0);
  assign div_rem  = {rem_q[RW-2:0], acc_q[PRODW-1]};
  assign div_ge   = div_rem >= RW'(opb_q);
  assign sq_rem   = {rem_q[RW-3:0], acc_q[PRODW-1 -: 2]};
  assign sq_trial = {1'b0, opb_q, 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;

  always_comb begin
    case (op_q)
      pcf_pkg::OP_DIV: last_cnt = CNTW'(PRODW - 1);
      default:         last_cnt = CNTW'(OPW - 1);
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      op_d   = req_i.op;
      cnt_d  = '0;
      busy_d = 1'b1;
      rem_d  = '0;
      case (req_i.op)
        pcf_pkg::OP_MUL: begin
          acc_d = '0;
          opa_d = req_i.a;
          opb_d = req_i.b;
        end
        pcf_pkg::OP_DIV: begin
          acc_d = req_i.a;
          opb_d = req_i.b;
        end
        default: begin
          acc_d = req_i.a;
          opb_d = '0;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        pcf_pkg::OP_MUL: begin
          acc_d = mul_sum;
          opa_d = opa_q << 1;
          opb_d = opb_q >> 1;
        end
        pcf_pkg::OP_DIV: begin
          rem_d = div_ge ? (div_rem - RW'(opb_q)) : div_rem;
          acc_d = {acc_q[PRODW-2:0], div_ge};
        end
        default: begin
          rem_d = sq_ge ? (sq_rem - sq_trial) : sq_rem;
          opb_d = {opb_q[OPW-2:0], sq_ge};
          acc_d = acc_q << 2;
        end
      endcase
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == last_cnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= pcf_pkg::OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    rem_q <= rem_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    case (op_q)
      pcf_pkg::OP_SQRT: rsp_o.res = PRODW'(opb_q);
      default:          rsp_o.res = acc_q;
    endcase
  end

endmodule

// File: src/pursuit_camera_follower.sv
// ----------------------------------------------------------------------------
// pursuit_camera_follower: two-dimensional pursuit follower
// Keeps a position and velocity in Q.8 fixed point, steers toward a target,
// limits speed, moves and clamps the position into a bounds rectangle.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------
//  in       | in        | in_valid_i / in_ready_o  | cmd_i, target_x_i, target_y_i
//  out      | out       | out_valid_o / out_ready_i| pos_x_o, pos_y_o
//  cfg      | in        | cfg_we_i                 | cfg_addr_i, cfg_wdata_i
//
// A snap result goes through ST_CLAMP into the output register. An update
// result takes longer, and longer still when the speed limit applies: every
// product, quotient and root goes through one shared serial unit, one bit per
// cycle, for a 25 x 25 multiply, a root of a 50 bit value or a 50 bit divide.
// One item is in work at a time.
// Reset clears position and velocity to zero and loads the register defaults.
// A finished result sits in the output register; the next item is taken while
// it waits, and the block stalls only when a new result finds it still full.
module pursuit_camera_follower (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pcf_pkg::CFG_IDX_W-1:0]          cfg_addr_i,
  input  logic [pcf_pkg::REG_W-1:0]              cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   cmd_i,
  input  logic signed [pcf_pkg::COORD_BITS-1:0]  target_x_i,
  input  logic signed [pcf_pkg::COORD_BITS-1:0]  target_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [pcf_pkg::COORD_BITS-1:0]  pos_x_o,
  output logic signed [pcf_pkg::COORD_BITS-1:0]  pos_y_o
);

  localparam int CW     = pcf_pkg::COORD_BITS;
  localparam int FB     = pcf_pkg::FRAC_BITS;
  localparam int RGW    = pcf_pkg::REG_W;
  localparam int VMAG_W = pcf_pkg::VMAG_W;
  localparam int VEL_W  = pcf_pkg::VEL_W;
  localparam int DIFF_W = pcf_pkg::DIFF_W;
  localparam int OPW    = pcf_pkg::OPW;
  localparam int PRODW  = pcf_pkg::PRODW;
  // position plus velocity before saturation
  localparam int SW     = ((CW > VEL_W) ? CW : VEL_W) + 1;
  // scaled bounds: 16 bit edge sum plus fraction bits
  localparam int EW     = 16 + FB;
  localparam int CMPW   = ((CW > EW) ? CW : EW) + 1;

  localparam logic [OPW-1:0]         NEAR_DIST = OPW'(8) << FB;
  localparam logic signed [CW-1:0]   POS_MAX   = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0]   POS_MIN   = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,     // square x component
    ST_SQY,     // square y component and sum
    ST_ROOT,    // length of the vector
    ST_ACCX,    // |dx| * gain
    ST_DIVAX,   // / den, add to vx
    ST_ACCY,
    ST_DIVAY,
    ST_LIMX,    // |vx| * max_speed
    ST_DIVLX,   // / len
    ST_LIMY,
    ST_DIVLY,
    ST_MOVE,
    ST_CLAMP
  } state_e;

  // configuration registers
  logic [RGW-1:0]        max_speed_q;
  logic [RGW-1:0]        accel_gain_q;
  logic signed [14:0]    bound_left_q;
  logic signed [14:0]    bound_top_q;
  logic [13:0]           bound_width_q;
  logic [13:0]           bound_height_q;

  state_e                    state_q, state_d;
  logic                      started_q, started_d;
  logic                      phase_q, phase_d;    // 0: distance, 1: velocity
  logic                      lim_q, lim_d;        // speed limit already applied
  logic signed [CW-1:0]      pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [VEL_W-1:0]   vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  logic signed [CW-1:0]      tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic signed [DIFF_W-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic [PRODW-1:0]          sq_q, sq_d;
  logic [OPW-1:0]            dist_q, dist_d;
  logic [OPW-1:0]            len_q, len_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [CW-1:0]      out_x_q, out_x_d, out_y_q, out_y_d;

  pcf_pkg::ser_req_t         ser_req;
  pcf_pkg::ser_rsp_t         ser_rsp;

  logic [DIFF_W-1:0]         dmag_x, dmag_y;
  logic [VMAG_W-1:0]         vmag_x, vmag_y;
  logic [OPW-1:0]            den;
  logic                      op_state;
  logic [VMAG_W-1:0]         quot;
  logic signed [VEL_W-1:0]   quot_s;
  logic signed [CW-1:0]      clamp_x, clamp_y;
  logic signed [DIFF_W-1:0]  neg_dx, neg_dy;
  logic signed [VEL_W-1:0]   neg_vx, neg_vy;

  function automatic logic signed [CW-1:0] sat_sum(logic signed [CW-1:0]    p,
                                                   logic signed [VEL_W-1:0] v);
    logic signed [SW-1:0] s;
    s = SW'(p) + SW'(v);
    if (s > SW'(POS_MAX)) begin
      return POS_MAX;
    end else if (s < SW'(POS_MIN)) begin
      return POS_MIN;
    end
    return s[CW-1:0];
  endfunction

  // clamp into [edge, edge + size] scaled to fixed point, then saturate
  function automatic logic signed [CW-1:0] clamp_axis(logic signed [CW-1:0] p,
                                                      logic signed [14:0]   lo_edge,
                                                      logic [13:0]          size);
    logic signed [CMPW-1:0] lo;
    logic signed [CMPW-1:0] hi;
    logic signed [CMPW-1:0] c;
    lo = CMPW'(lo_edge) <<< FB;
    hi = (CMPW'(lo_edge) + CMPW'(signed'({1'b0, size}))) <<< FB;
    c  = CMPW'(p);
    if (c < lo) begin
      c = lo;
    end
    if (c > hi) begin
      c = hi;
    end
    if (c > CMPW'(POS_MAX)) begin
      return POS_MAX;
    end else if (c < CMPW'(POS_MIN)) begin
      return POS_MIN;
    end
    return c[CW-1:0];
  endfunction

  pcf_serial u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ser_req),
    .rsp_o  (ser_rsp)
  );

  // magnitudes fed to the serial unit
  assign neg_dx = -dx_q;
  assign neg_dy = -dy_q;
  assign neg_vx = -vel_x_q;
  assign neg_vy = -vel_y_q;
  assign dmag_x = dx_q[DIFF_W-1] ? neg_dx : dx_q;
  assign dmag_y = dy_q[DIFF_W-1] ? neg_dy : dy_q;
  assign vmag_x = vel_x_q[VEL_W-1] ? neg_vx[VMAG_W-1:0] : vel_x_q[VMAG_W-1:0];
  assign vmag_y = vel_y_q[VEL_W-1] ? neg_vy[VMAG_W-1:0] : vel_y_q[VMAG_W-1:0];
  assign den    = (dist_q > NEAR_DIST) ? dist_q : NEAR_DIST;

  // quotients never exceed the 16 bit gain or speed limit
  assign quot   = ser_rsp.res[VMAG_W-1:0];
  assign quot_s = signed'({1'b0, quot});

  assign clamp_x = clamp_axis(pos_x_q, bound_left_q, bound_width_q);
  assign clamp_y = clamp_axis(pos_y_q, bound_top_q, bound_height_q);

  assign op_state = (state_q != ST_IDLE) && (state_q != ST_MOVE) &&
                    (state_q != ST_CLAMP);

  // operand select for the serial unit; start once on entry to a state
  always_comb begin
    ser_req.start = op_state && !started_q;
    ser_req.op    = pcf_pkg::OP_MUL;
    ser_req.a     = '0;
    ser_req.b     = '0;
    case (state_q)
      ST_SQX: begin
        ser_req.a = phase_q ? PRODW'(vmag_x) : PRODW'(dmag_x);
        ser_req.b = phase_q ? OPW'(vmag_x) : OPW'(dmag_x);
      end
      ST_SQY: begin
        ser_req.a = phase_q ? PRODW'(vmag_y) : PRODW'(dmag_y);
        ser_req.b = phase_q ? OPW'(vmag_y) : OPW'(dmag_y);
      end
      ST_ROOT: begin
        ser_req.op = pcf_pkg::OP_SQRT;
        ser_req.a  = sq_q;
      end
      ST_ACCX: begin
        ser_req.a = PRODW'(dmag_x);
        ser_req.b = OPW'(accel_gain_q);
      end
      ST_ACCY: begin
        ser_req.a = PRODW'(dmag_y);
        ser_req.b = OPW'(accel_gain_q);
      end
      ST_DIVAX, ST_DIVAY: begin
        // the product is still held in the unit
        ser_req.op = pcf_pkg::OP_DIV;
        ser_req.a  = ser_rsp.res;
        ser_req.b  = den;
      end
      ST_LIMX: begin
        ser_req.a = PRODW'(vmag_x);
        ser_req.b = OPW'(max_speed_q);
      end
      ST_LIMY: begin
        ser_req.a = PRODW'(vmag_y);
        ser_req.b = OPW'(max_speed_q);
      end
      ST_DIVLX, ST_DIVLY: begin
        ser_req.op = pcf_pkg::OP_DIV;
        ser_req.a  = ser_rsp.res;
        ser_req.b  = len_q;
      end
      default: begin
        ser_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    started_d   = started_q;
    phase_d     = phase_q;
    lim_d       = lim_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    vel_x_d     = vel_x_q;
    vel_y_d     = vel_y_q;
    tgt_x_d     = tgt_x_q;
    tgt_y_d     = tgt_y_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    sq_d        = sq_q;
    dist_d      = dist_q;
    len_d       = len_q;
    out_valid_d = out_valid_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;

    // drop the result once it has been transferred
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (ser_req.start) begin
      started_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          tgt_x_d = target_x_i;
          tgt_y_d = target_y_i;
          if (cmd_i) begin
            pos_x_d = target_x_i;
            pos_y_d = target_y_i;
            state_d = ST_CLAMP;
          end else begin
            dx_d    = DIFF_W'(target_x_i) - DIFF_W'(pos_x_q);
            dy_d    = DIFF_W'(target_y_i) - DIFF_W'(pos_y_q);
            phase_d = 1'b0;
            lim_d   = 1'b0;
            state_d = ST_SQX;
          end
        end
      end
      ST_MOVE: begin
        if (len_q > dist_q) begin
          pos_x_d = tgt_x_q;
          pos_y_d = tgt_y_q;
        end else begin
          pos_x_d = sat_sum(pos_x_q, vel_x_q);
          pos_y_d = sat_sum(pos_y_q, vel_y_q);
        end
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          pos_x_d     = clamp_x;
          pos_y_d     = clamp_y;
          out_x_d     = clamp_x;
          out_y_d     = clamp_y;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        if (started_q && ser_rsp.done) begin
          started_d = 1'b0;
          case (state_q)
            ST_SQX: begin
              sq_d    = ser_rsp.res;
              state_d = ST_SQY;
            end
            ST_SQY: begin
              sq_d    = sq_q + ser_rsp.res;
              state_d = ST_ROOT;
            end
            ST_ROOT: begin
              if (!phase_q) begin
                dist_d  = ser_rsp.res[OPW-1:0];
                state_d = ST_ACCX;
              end else begin
                len_d = ser_rsp.res[OPW-1:0];
                if (!lim_q && (ser_rsp.res[OPW-1:0] > OPW'(max_speed_q))) begin
                  lim_d   = 1'b1;
                  state_d = ST_LIMX;
                end else begin
                  state_d = ST_MOVE;
                end
              end
            end
            ST_ACCX:  state_d = ST_DIVAX;
            ST_DIVAX: begin
              vel_x_d = dx_q[DIFF_W-1] ? (vel_x_q - quot_s) : (vel_x_q + quot_s);
              state_d = ST_ACCY;
            end
            ST_ACCY:  state_d = ST_DIVAY;
            ST_DIVAY: begin
              vel_y_d = dy_q[DIFF_W-1] ? (vel_y_q - quot_s) : (vel_y_q + quot_s);
              phase_d = 1'b1;
              state_d = ST_SQX;
            end
            ST_LIMX:  state_d = ST_DIVLX;
            ST_DIVLX: begin
              vel_x_d = vel_x_q[VEL_W-1] ? -quot_s : quot_s;
              state_d = ST_LIMY;
            end
            ST_LIMY:  state_d = ST_DIVLY;
            ST_DIVLY: begin
              vel_y_d = vel_y_q[VEL_W-1] ? -quot_s : quot_s;
              // measure the limited velocity again
              state_d = ST_SQX;
            end
            default:  state_d = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      started_q      <= 1'b0;
      phase_q        <= 1'b0;
      lim_q          <= 1'b0;
      pos_x_q        <= '0;
      pos_y_q        <= '0;
      vel_x_q        <= '0;
      vel_y_q        <= '0;
      out_valid_q    <= 1'b0;
      max_speed_q    <= RGW'(1024);
      accel_gain_q   <= RGW'(256);
      bound_left_q   <= '0;
      bound_top_q    <= '0;
      bound_width_q  <= 14'd1024;
      bound_height_q <= 14'd1024;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      phase_q     <= phase_d;
      lim_q       <= lim_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      vel_x_q     <= vel_x_d;
      vel_y_q     <= vel_y_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          pcf_pkg::REG_MAX_SPEED:    max_speed_q    <= cfg_wdata_i;
          pcf_pkg::REG_ACCEL_GAIN:   accel_gain_q   <= cfg_wdata_i;
          pcf_pkg::REG_BOUND_LEFT:   bound_left_q   <= cfg_wdata_i[14:0];
          pcf_pkg::REG_BOUND_TOP:    bound_top_q    <= cfg_wdata_i[14:0];
          pcf_pkg::REG_BOUND_WIDTH:  bound_width_q  <= cfg_wdata_i[13:0];
          pcf_pkg::REG_BOUND_HEIGHT: bound_height_q <= cfg_wdata_i[13:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tgt_x_q <= tgt_x_d;
    tgt_y_q <= tgt_y_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    sq_q    <= sq_d;
    dist_q  <= dist_d;
    len_q   <= len_d;
    out_x_q <= out_x_d;
    out_y_q <= out_y_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;

endmodule
